>>> hdl/tlca_pkg.sv
package tlca_pkg;

    // Fixed field widths of the transaction payloads
    localparam int NODE_W  = 10;
    localparam int DEPTH_W = 10;
    localparam int PATH_W  = 11;

    // Largest depth kept; deeper children saturate here
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

    // Function codes of an input transaction
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [DEPTH_W-1:0] depth_t;
    typedef logic [PATH_W-1:0]  path_t;

endpackage

>>> hdl/tlca_ram.sv
module tlca_ram #(
    parameter int WIDTH  = 10,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] ram_reg [2**ADDR_W];
    logic [WIDTH-1:0] rdata_reg;

    // Write port, registered read with write-first forwarding
    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
        if (we && (waddr == raddr)) begin
            rdata_reg <= wdata;
        end else begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/tree_lca_distance_engine.sv
// One transaction at a time. Add: one depth access, then one ancestor table access per level.
// Query: both depths are read, the deeper node is lifted to the other's depth by lifting jumps,
// both then climb while their ancestors differ (not when the lift already meets), and the
// ancestor's depth is read; the single table read port serialises these accesses, and a full
// output register holds the result. Node numbers are reduced modulo NODES if NODES < 1024.
// aresetn (synchronous, active low) clears sequencer and output valid; tables are not cleared.
module tree_lca_distance_engine #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_func,
    input  tlca_pkg::node_t s_node_a,
    input  tlca_pkg::node_t s_node_b,
    output logic            m_valid,
    input  logic            m_ready,
    output tlca_pkg::node_t m_common_ancestor,
    output tlca_pkg::path_t m_path_vertices
);

    import tlca_pkg::*;

    localparam int  NW          = (NODES > 2) ? $clog2(NODES) : 1;
    localparam int  LW          = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int  AW          = NW + LW;
    localparam int  RED_W       = 28;
    localparam int  STRIDE_W    = 17;
    localparam int  SUM_W       = 13;
    localparam bit  NEED_REDUCE = (NODES < (2 ** NODE_W));
    localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_REDUCE = 5'd1;
    localparam logic [4:0] S_START  = 5'd2;
    localparam logic [4:0] S_ROOT   = 5'd3;
    localparam logic [4:0] S_ADD_D  = 5'd4;
    localparam logic [4:0] S_ADD_L  = 5'd5;
    localparam logic [4:0] S_QD_A   = 5'd6;
    localparam logic [4:0] S_QD_B   = 5'd7;
    localparam logic [4:0] S_LIFT   = 5'd8;
    localparam logic [4:0] S_LIFT_W = 5'd9;
    localparam logic [4:0] S_CHECK  = 5'd10;
    localparam logic [4:0] S_CL_A   = 5'd11;
    localparam logic [4:0] S_CL_B   = 5'd12;
    localparam logic [4:0] S_CL_C   = 5'd13;
    localparam logic [4:0] S_FIN    = 5'd14;
    localparam logic [4:0] S_QD_C   = 5'd15;
    localparam logic [4:0] S_EMIT   = 5'd16;

    logic [4:0]    state_reg, state_next;
    logic          func_reg, func_next;
    node_t         ra_reg, ra_next;
    node_t         rb_reg, rb_next;
    logic [3:0]    red_k_reg, red_k_next;
    logic [LW-1:0] lvl_reg, lvl_next;
    logic [NW-1:0] lo_reg, lo_next;
    logic [NW-1:0] hi_reg, hi_next;
    logic [NW-1:0] pl_reg, pl_next;
    logic [NW-1:0] c_reg, c_next;
    depth_t        rest_reg, rest_next;
    depth_t        da_reg, da_next;
    depth_t        db_reg, db_next;
    depth_t        dc_reg, dc_next;
    logic          m_valid_reg, m_valid_next;
    node_t         m_anc_reg, m_anc_next;
    path_t         m_path_reg, m_path_next;

    logic [NW-1:0] a_idx, b_idx;

    logic          anc_we;
    logic [NW-1:0] anc_wnode, anc_rnode;
    logic [LW-1:0] anc_wlvl, anc_rlvl;
    logic [NW-1:0] anc_wdata, anc_rdata;
    logic          dep_we;
    logic [NW-1:0] dep_waddr, dep_raddr;
    depth_t        dep_wdata, dep_rdata;

    logic [RED_W-1:0]    red_lim;
    logic [STRIDE_W-1:0] stride;
    logic signed [SUM_W-1:0] path_sum;

    tlca_ram #(
        .WIDTH  (NW),
        .ADDR_W (AW)
    ) u_anc_ram (
        .aclk  (aclk),
        .we    (anc_we),
        .waddr ({anc_wnode, anc_wlvl}),
        .wdata (anc_wdata),
        .raddr ({anc_rnode, anc_rlvl}),
        .rdata (anc_rdata)
    );

    tlca_ram #(
        .WIDTH  (DEPTH_W),
        .ADDR_W (NW)
    ) u_dep_ram (
        .aclk  (aclk),
        .we    (dep_we),
        .waddr (dep_waddr),
        .wdata (dep_wdata),
        .raddr (dep_raddr),
        .rdata (dep_rdata)
    );

    // Node indexes after reduction
    assign a_idx   = NW'(ra_reg);
    assign b_idx   = NW'(rb_reg);
    assign red_lim = RED_W'(NODES) << red_k_reg;
    assign stride  = STRIDE_W'(1) << lvl_reg;

    // Vertex count on the path, before clamping to the legal range
    always_comb begin
        path_sum = $signed({3'b000, da_reg}) + $signed({3'b000, db_reg})
                 - $signed({2'b00, dc_reg, 1'b0}) + $signed(SUM_W'(1));
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        func_next    = func_reg;
        ra_next      = ra_reg;
        rb_next      = rb_reg;
        red_k_next   = red_k_reg;
        lvl_next     = lvl_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        pl_next      = pl_reg;
        c_next       = c_reg;
        rest_next    = rest_reg;
        da_next      = da_reg;
        db_next      = db_reg;
        dc_next      = dc_reg;
        m_valid_next = m_valid_reg;
        m_anc_next   = m_anc_reg;
        m_path_next  = m_path_reg;

        anc_we    = 1'b0;
        anc_wnode = a_idx;
        anc_wlvl  = lvl_reg;
        anc_wdata = a_idx;
        anc_rnode = hi_reg;
        anc_rlvl  = lvl_reg;
        dep_we    = 1'b0;
        dep_waddr = a_idx;
        dep_wdata = '0;
        dep_raddr = a_idx;

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    func_next  = s_func;
                    ra_next    = s_node_a;
                    rb_next    = s_node_b;
                    red_k_next = 4'd9;
                    state_next = NEED_REDUCE ? S_REDUCE : S_START;
                end
            end

            // Restoring reduction of both node numbers modulo NODES
            S_REDUCE: begin
                if ({{(RED_W-NODE_W){1'b0}}, ra_reg} >= red_lim) begin
                    ra_next = ra_reg - NODE_W'(red_lim);
                end
                if ({{(RED_W-NODE_W){1'b0}}, rb_reg} >= red_lim) begin
                    rb_next = rb_reg - NODE_W'(red_lim);
                end
                if (red_k_reg == 4'd0) begin
                    state_next = S_START;
                end else begin
                    red_k_next = red_k_reg - 4'd1;
                end
            end

            S_START: begin
                if (func_reg == FUNC_ADD) begin
                    if (a_idx == b_idx) begin
                        dep_we     = 1'b1;
                        dep_wdata  = '0;
                        lvl_next   = '0;
                        state_next = S_ROOT;
                    end else begin
                        dep_raddr  = b_idx;
                        state_next = S_ADD_D;
                    end
                end else begin
                    dep_raddr  = a_idx;
                    state_next = S_QD_A;
                end
            end

            // Root: every level points at the node itself
            S_ROOT: begin
                anc_we    = 1'b1;
                anc_wdata = a_idx;
                if (lvl_reg == LVL_TOP) begin
                    state_next = S_IDLE;
                end else begin
                    lvl_next = lvl_reg + LW'(1);
                end
            end

            // Child: depth from parent, level 0 is the parent
            S_ADD_D: begin
                dep_we    = 1'b1;
                dep_wdata = (dep_rdata == DEPTH_MAX) ? DEPTH_MAX : dep_rdata + DEPTH_W'(1);
                anc_we    = 1'b1;
                anc_wlvl  = '0;
                anc_wdata = b_idx;
                anc_rnode = b_idx;
                anc_rlvl  = '0;
                lvl_next  = LW'(1);
                state_next = (LEVELS > 1) ? S_ADD_L : S_IDLE;
            end

            // Level i is level i-1 of the level i-1 ancestor
            S_ADD_L: begin
                anc_we    = 1'b1;
                anc_wdata = anc_rdata;
                anc_rnode = anc_rdata;
                anc_rlvl  = lvl_reg;
                if (lvl_reg == LVL_TOP) begin
                    state_next = S_IDLE;
                end else begin
                    lvl_next = lvl_reg + LW'(1);
                end
            end

            S_QD_A: begin
                da_next    = dep_rdata;
                dep_raddr  = b_idx;
                state_next = S_QD_B;
            end

            // Put the deeper node in hi and its depth surplus in rest
            S_QD_B: begin
                db_next = dep_rdata;
                if (da_reg > dep_rdata) begin
                    lo_next   = b_idx;
                    hi_next   = a_idx;
                    rest_next = da_reg - dep_rdata;
                end else begin
                    lo_next   = a_idx;
                    hi_next   = b_idx;
                    rest_next = dep_rdata - da_reg;
                end
                lvl_next   = LVL_TOP;
                state_next = S_LIFT;
            end

            // Lift hi to the depth of lo
            S_LIFT: begin
                anc_rnode = hi_reg;
                anc_rlvl  = lvl_reg;
                if ({{(STRIDE_W-DEPTH_W){1'b0}}, rest_reg} >= stride) begin
                    state_next = S_LIFT_W;
                end else if (lvl_reg == '0) begin
                    state_next = S_CHECK;
                end else begin
                    lvl_next = lvl_reg - LW'(1);
                end
            end

            S_LIFT_W: begin
                hi_next    = anc_rdata;
                rest_next  = rest_reg - DEPTH_W'(stride);
                state_next = S_LIFT;
            end

            S_CHECK: begin
                if (lo_reg == hi_reg) begin
                    c_next     = lo_reg;
                    dep_raddr  = lo_reg;
                    state_next = S_QD_C;
                end else begin
                    lvl_next   = LVL_TOP;
                    state_next = S_CL_A;
                end
            end

            // Climb both nodes while their ancestors differ
            S_CL_A: begin
                anc_rnode  = lo_reg;
                anc_rlvl   = lvl_reg;
                state_next = S_CL_B;
            end

            S_CL_B: begin
                pl_next    = anc_rdata;
                anc_rnode  = hi_reg;
                anc_rlvl   = lvl_reg;
                state_next = S_CL_C;
            end

            S_CL_C: begin
                if (pl_reg != anc_rdata) begin
                    lo_next = pl_reg;
                    hi_next = anc_rdata;
                end
                if (lvl_reg == '0) begin
                    anc_rnode  = (pl_reg != anc_rdata) ? pl_reg : lo_reg;
                    anc_rlvl   = '0;
                    state_next = S_FIN;
                end else begin
                    lvl_next   = lvl_reg - LW'(1);
                    state_next = S_CL_A;
                end
            end

            S_FIN: begin
                c_next     = anc_rdata;
                dep_raddr  = anc_rdata;
                state_next = S_QD_C;
            end

            S_QD_C: begin
                dc_next    = dep_rdata;
                state_next = S_EMIT;
            end

            // Hold until the output register is free
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_anc_next   = NODE_W'(c_reg);
                    if (path_sum < $signed(SUM_W'(1))) begin
                        m_path_next = PATH_W'(1);
                    end else if (path_sum > $signed(SUM_W'(2047))) begin
                        m_path_next = PATH_W'(2047);
                    end else begin
                        m_path_next = PATH_W'(path_sum);
                    end
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        red_k_reg  <= red_k_next;
        lvl_reg    <= lvl_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        pl_reg     <= pl_next;
        c_reg      <= c_next;
        rest_reg   <= rest_next;
        da_reg     <= da_next;
        db_reg     <= db_next;
        dc_reg     <= dc_next;
        m_anc_reg  <= m_anc_next;
        m_path_reg <= m_path_next;
    end

    assign s_ready           = (state_reg == S_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_common_ancestor = m_anc_reg;
    assign m_path_vertices   = m_path_reg;

endmodule
